// ----- hdl/mslsu_pkg.sv -----
// Shared types and constants for the motion safety lease supervisor.
// No dependencies; imported by the interfaces, the event queue, the core and the top level.
`default_nettype none

package mslsu_pkg;

  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;
  localparam int CNT_OUT_W = 16;
  localparam int KIND_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] LEASE_MS_RST = 32'd1000;
  localparam logic [TIME_W-1:0] LINE_LIMIT_RST = 32'd500;

  typedef enum logic [KIND_W-1:0] {
    K_STOP       = 4'd0,
    K_RESTORE    = 4'd1,
    K_START      = 4'd2,
    K_HB_FRAME   = 4'd3,
    K_HB_CONSUME = 4'd4,
    K_LEASE_TICK = 4'd5,
    K_LINE_LOST  = 4'd6,
    K_LINE_FOUND = 4'd7,
    K_TIMEOUT    = 4'd8,
    K_APPLY      = 4'd9,
    K_REANNOUNCE = 4'd10,
    K_POP        = 4'd11
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEASE_MS   = 1'b0,
    REG_LINE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_INIT    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_STOPPED = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    RS_INHIBITED = 3'd0,
    RS_START     = 3'd1,
    RS_STOP      = 3'd2,
    RS_RESTORE   = 3'd3,
    RS_TIMEOUT   = 3'd4,
    RS_LINE_LOST = 3'd5
  } reason_e;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_STOP      = 3'd1,
    CAUSE_RESTORE   = 3'd2,
    CAUSE_TIMEOUT   = 3'd3,
    CAUSE_LINE_LOST = 3'd4,
    CAUSE_HEARTBEAT = 3'd5
  } cause_e;

  typedef struct packed {
    state_e              state;
    reason_e             reason;
    logic [TIME_W-1:0]   tick;
  } status_t;

  // request from the core to the event queue
  typedef struct packed {
    logic    push;
    logic    pop;
    status_t entry;
  } evq_req_t;

  // queue head and cached status back to the core
  typedef struct packed {
    logic    nonempty;
    status_t head;
    state_e  cached_state;
    reason_e cached_reason;
  } evq_rsp_t;

  typedef struct packed {
    logic                 stop_fired;
    logic                 motion_locked;
    logic                 lease_active;
    logic                 controller_reset;
    logic                 status_valid;
    state_e               status_state;
    reason_e              status_reason;
    logic [TIME_W-1:0]    status_tick;
    logic [CNT_OUT_W-1:0] heartbeat_count;
    logic [CNT_OUT_W-1:0] lease_timeout_count;
    cause_e               stop_cause;
    logic [TIME_W-1:0]    heartbeat_age;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/mslsu_if.sv -----
// Channel interfaces: event input, result output and configuration write.
// Depends on mslsu_pkg for field widths.
`default_nettype none

interface mslsu_evt_if;
  import mslsu_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, kind, now_ms, input ready);
  modport sink   (input valid, kind, now_ms, output ready);
endinterface

interface mslsu_res_if;
  import mslsu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 stop_fired;
  logic                 motion_locked;
  logic                 lease_active;
  logic                 controller_reset;
  logic                 status_valid;
  logic [1:0]           status_state;
  logic [2:0]           status_reason;
  logic [TIME_W-1:0]    status_tick;
  logic [CNT_OUT_W-1:0] heartbeat_count;
  logic [CNT_OUT_W-1:0] lease_timeout_count;
  logic [2:0]           stop_cause;
  logic [TIME_W-1:0]    heartbeat_age;
  modport source (output valid, stop_fired, motion_locked, lease_active, controller_reset,
                  status_valid, status_state, status_reason, status_tick, heartbeat_count,
                  lease_timeout_count, stop_cause, heartbeat_age, input ready);
  modport sink   (input valid, stop_fired, motion_locked, lease_active, controller_reset,
                  status_valid, status_state, status_reason, status_tick, heartbeat_count,
                  lease_timeout_count, stop_cause, heartbeat_age, output ready);
endinterface

interface mslsu_cfg_if;
  import mslsu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/motion_safety_lease_supervisor.sv -----
// Motion safety lease supervisor: top level with input stage, configuration registers and
// result register. Depends on mslsu_pkg, the mslsu interfaces and mslsu_core.
//
// Usage:
//   evt_i  - event transactions (kind, now_ms); one event per transaction.
//   res_o  - one result transaction per event, in event order.
//   cfg_i  - register writes: index 0 lease_ms, index 1 line_lost_limit_ms. Always ready;
//            write only while no event is in flight.
// Datapath: an accepted event is held in the input register and evaluated from there; its
//   result is loaded into the result register, from which res_o offers it.
// Throughput: one event per cycle while res_o.ready is high; the state update is a
//   single pass of compares and register loads between the input and result registers.
// Reset: motion inhibited, counters and timers cleared, lease 1000 ms, line-loss limit
//   500 ms, status queue holding one INIT / MOTION_INHIBITED entry.
// Stall: while res_o.ready is low the finished result holds in the result register and
//   one further event may wait in the input register; evt_i.ready then drops.
`default_nettype none

module motion_safety_lease_supervisor #(
  parameter int EVENT_DEPTH = 4
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  mslsu_evt_if.sink  evt_i,
  mslsu_res_if.source res_o,
  mslsu_cfg_if.sink  cfg_i
);
  import mslsu_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [KIND_W-1:0] in_kind_q;
  logic [TIME_W-1:0] in_now_q;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;
  res_t              core_res;
  logic [TIME_W-1:0] lease_ms_q, line_limit_q;
  logic              advance, evt_acc;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;
  assign evt_acc     = evt_i.valid && evt_i.ready;
  assign in_valid_d  = evt_acc || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !res_o.ready);
  assign cfg_i.ready = 1'b1;

  mslsu_core #(
    .EVENT_DEPTH(EVENT_DEPTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .kind_i       (in_kind_q),
    .now_i        (in_now_q),
    .lease_ms_i   (lease_ms_q),
    .line_limit_i (line_limit_q),
    .res_o        (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      in_kind_q <= evt_i.kind;
      in_now_q  <= evt_i.now_ms;
    end
    if (advance) begin
      out_q <= core_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lease_ms_q   <= LEASE_MS_RST;
      line_limit_q <= LINE_LIMIT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_LEASE_MS:   lease_ms_q   <= cfg_i.data;
        REG_LINE_LIMIT: line_limit_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.stop_fired          = out_q.stop_fired;
  assign res_o.motion_locked       = out_q.motion_locked;
  assign res_o.lease_active        = out_q.lease_active;
  assign res_o.controller_reset    = out_q.controller_reset;
  assign res_o.status_valid        = out_q.status_valid;
  assign res_o.status_state        = out_q.status_state;
  assign res_o.status_reason       = out_q.status_reason;
  assign res_o.status_tick         = out_q.status_tick;
  assign res_o.heartbeat_count     = out_q.heartbeat_count;
  assign res_o.lease_timeout_count = out_q.lease_timeout_count;
  assign res_o.stop_cause          = out_q.stop_cause;
  assign res_o.heartbeat_age       = out_q.heartbeat_age;

`ifndef SYNTHESIS
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_kind_q) && $stable(in_now_q))
    else $error("waiting event lost from input stage");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed event produced no result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |-> !advance)
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- hdl/mslsu_evq.sv -----
// Status event queue: overwrite-oldest FIFO of status entries plus the cached last status.
// Depends on mslsu_pkg.
`default_nettype none

module mslsu_evq #(
  parameter int EVENT_DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire mslsu_pkg::evq_req_t req_i,
  output mslsu_pkg::evq_rsp_t      rsp_o
);
  import mslsu_pkg::*;

  localparam int PW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int FW = $clog2(EVENT_DEPTH + 1);
  localparam int SW = FW + 1;

  status_t          store_q [EVENT_DEPTH];
  logic [PW-1:0]    wp_q, wp_d;
  logic [FW-1:0]    fill_q, fill_d;
  state_e           cst_q;
  reason_e          crs_q;
  logic [SW-1:0]    tail_sum;
  logic [SW-1:0]    tail_ext;
  logic [PW-1:0]    tail;

  always_comb begin
    tail_sum = SW'(wp_q) + SW'(EVENT_DEPTH) - SW'(fill_q);
    tail_ext = (tail_sum >= SW'(EVENT_DEPTH)) ? tail_sum - SW'(EVENT_DEPTH) : tail_sum;
    tail     = tail_ext[PW-1:0];
  end

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (en_i && req_i.push) begin
      wp_d = (wp_q == PW'(EVENT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != FW'(EVENT_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end else if (en_i && req_i.pop && (fill_q != '0)) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= PW'(1 % EVENT_DEPTH);
      fill_q <= FW'(1);
      cst_q  <= ST_INIT;
      crs_q  <= RS_INHIBITED;
      for (int i = 0; i < EVENT_DEPTH; i++) begin
        store_q[i] <= '{state: ST_INIT, reason: RS_INHIBITED, tick: '0};
      end
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      if (en_i && req_i.push) begin
        store_q[wp_q] <= req_i.entry;
        cst_q         <= req_i.entry.state;
        crs_q         <= req_i.entry.reason;
      end
    end
  end

  assign rsp_o.nonempty      = (fill_q != '0);
  assign rsp_o.head          = store_q[tail];
  assign rsp_o.cached_state  = cst_q;
  assign rsp_o.cached_reason = crs_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(EVENT_DEPTH))
    else $error("event queue fill beyond depth");

  a_full_push_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.push && (fill_q == FW'(EVENT_DEPTH)) |=> fill_q == FW'(EVENT_DEPTH))
    else $error("push on full queue changed fill");

  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.pop && !req_i.push && (fill_q != '0) |=> fill_q == $past(fill_q) - 1'b1)
    else $error("pop did not remove one entry");

  a_push_advances_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.push |=> wp_q != $past(wp_q) || EVENT_DEPTH == 1)
    else $error("push did not advance write pointer");
`endif

endmodule

`default_nettype wire

// ----- hdl/mslsu_core.sv -----
// Supervisor state and per-event update logic; produces one result per processed event.
// Depends on mslsu_pkg and mslsu_evq.
`default_nettype none

module mslsu_core #(
  parameter int EVENT_DEPTH = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [mslsu_pkg::KIND_W-1:0] kind_i,
  input  wire logic [mslsu_pkg::TIME_W-1:0] now_i,
  input  wire logic [mslsu_pkg::TIME_W-1:0] lease_ms_i,
  input  wire logic [mslsu_pkg::TIME_W-1:0] line_limit_i,
  output mslsu_pkg::res_t                   res_o
);
  import mslsu_pkg::*;

  logic              inh_q, inh_d;
  logic              rb_q, rb_d;
  logic              run_q, run_d;
  logic [TIME_W-1:0] lease_start_q, lease_start_d;
  logic [TIME_W-1:0] seen_q, seen_d;
  logic              hbp_q, hbp_d;
  logic [CNT_W-1:0]  hb_total_q, hb_total_d;
  logic [CNT_W-1:0]  exp_total_q, exp_total_d;
  cause_e            cause_q, cause_d;
  logic              loss_q, loss_d;
  logic [TIME_W-1:0] loss_start_q, loss_start_d;

  evq_req_t          req;
  evq_rsp_t          rsp;
  logic              fired, creset, pop_hit;
  logic [TIME_W-1:0] lease_elapsed, loss_elapsed, lease_after;

  assign lease_elapsed = now_i - lease_start_q;
  assign loss_elapsed  = now_i - loss_start_q;

  always_comb begin
    inh_d         = inh_q;
    rb_d          = rb_q;
    run_d         = run_q;
    lease_start_d = lease_start_q;
    seen_d        = seen_q;
    hbp_d         = hbp_q;
    hb_total_d    = hb_total_q;
    exp_total_d   = exp_total_q;
    cause_d       = cause_q;
    loss_d        = loss_q;
    loss_start_d  = loss_start_q;
    fired         = 1'b0;
    creset        = 1'b0;
    req.push      = 1'b0;
    req.pop       = 1'b0;
    req.entry     = '{state: ST_STOPPED, reason: RS_STOP, tick: '0};

    case (kind_e'(kind_i))
      K_STOP, K_RESTORE, K_TIMEOUT: begin
        rb_d     = 1'b1;
        inh_d    = 1'b1;
        run_d    = 1'b0;
        req.push = 1'b1;
        if (kind_e'(kind_i) == K_STOP) begin
          cause_d          = CAUSE_STOP;
          req.entry.reason = RS_STOP;
        end else if (kind_e'(kind_i) == K_RESTORE) begin
          cause_d          = CAUSE_RESTORE;
          req.entry.reason = RS_RESTORE;
        end else begin
          cause_d          = CAUSE_TIMEOUT;
          req.entry.reason = RS_TIMEOUT;
        end
      end
      K_START: begin
        if (!rb_q) begin
          inh_d     = 1'b0;
          req.push  = 1'b1;
          req.entry = '{state: ST_RUNNING, reason: RS_START, tick: '0};
        end
      end
      K_HB_FRAME: begin
        hb_total_d = hb_total_q + 1'b1;
        hbp_d      = 1'b1;
      end
      K_HB_CONSUME: begin
        if (hbp_q) begin
          hbp_d  = 1'b0;
          seen_d = now_i;
          if (!inh_q) begin
            lease_start_d = now_i;
          end
        end
      end
      K_LEASE_TICK: begin
        if (!inh_q) begin
          if (!run_q) begin
            lease_start_d = now_i;
            run_d         = 1'b1;
          end else if (lease_elapsed >= lease_ms_i) begin
            exp_total_d = exp_total_q + 1'b1;
            rb_d        = 1'b1;
            inh_d       = 1'b1;
            run_d       = 1'b0;
            cause_d     = CAUSE_HEARTBEAT;
            req.push    = 1'b1;
            req.entry   = '{state: ST_STOPPED, reason: RS_TIMEOUT, tick: '0};
            fired       = 1'b1;
          end
        end
      end
      K_LINE_LOST: begin
        if (!inh_q) begin
          if (!loss_q) begin
            loss_d       = 1'b1;
            loss_start_d = now_i;
          end else if (loss_elapsed >= line_limit_i) begin
            rb_d      = 1'b1;
            inh_d     = 1'b1;
            run_d     = 1'b0;
            cause_d   = CAUSE_LINE_LOST;
            req.push  = 1'b1;
            req.entry = '{state: ST_STOPPED, reason: RS_LINE_LOST, tick: now_i};
            fired     = 1'b1;
          end
        end
      end
      K_LINE_FOUND: begin
        loss_d       = 1'b0;
        loss_start_d = '0;
      end
      K_APPLY: begin
        if (rb_q) begin
          rb_d   = 1'b0;
          creset = 1'b1;
        end
      end
      K_REANNOUNCE: begin
        req.push  = 1'b1;
        req.entry = '{state: rsp.cached_state, reason: rsp.cached_reason, tick: '0};
      end
      K_POP: begin
        req.pop = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mslsu_evq #(
    .EVENT_DEPTH(EVENT_DEPTH)
  ) u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inh_q         <= 1'b1;
      rb_q          <= 1'b0;
      run_q         <= 1'b0;
      lease_start_q <= '0;
      seen_q        <= '0;
      hbp_q         <= 1'b0;
      hb_total_q    <= '0;
      exp_total_q   <= '0;
      cause_q       <= CAUSE_NONE;
      loss_q        <= 1'b0;
      loss_start_q  <= '0;
    end else if (en_i) begin
      inh_q         <= inh_d;
      rb_q          <= rb_d;
      run_q         <= run_d;
      lease_start_q <= lease_start_d;
      seen_q        <= seen_d;
      hbp_q         <= hbp_d;
      hb_total_q    <= hb_total_d;
      exp_total_q   <= exp_total_d;
      cause_q       <= cause_d;
      loss_q        <= loss_d;
      loss_start_q  <= loss_start_d;
    end
  end

  assign pop_hit     = req.pop && rsp.nonempty;
  assign lease_after = now_i - lease_start_d;

  always_comb begin
    res_o.stop_fired          = fired;
    res_o.motion_locked       = inh_d;
    res_o.lease_active        = !inh_d && (lease_after < lease_ms_i);
    res_o.controller_reset    = creset;
    res_o.status_valid        = pop_hit;
    res_o.status_state        = pop_hit ? rsp.head.state : ST_INIT;
    res_o.status_reason       = pop_hit ? rsp.head.reason : RS_INHIBITED;
    res_o.status_tick         = pop_hit ? rsp.head.tick : '0;
    res_o.heartbeat_count     = hb_total_d[CNT_OUT_W-1:0];
    res_o.lease_timeout_count = exp_total_d[CNT_OUT_W-1:0];
    res_o.stop_cause          = cause_d;
    res_o.heartbeat_age       = (hb_total_d == '0) ? '1 : now_i - seen_d;
  end

`ifndef SYNTHESIS
  a_fire_inhibits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && fired |=> inh_q && rb_q && !run_q)
    else $error("forced stop left motion enabled");

  a_apply_clears_rollback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && creset |=> !rb_q)
    else $error("apply left rollback pending");

  a_start_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && rb_q && (kind_e'(kind_i) == K_START) |=> inh_q)
    else $error("start lifted inhibit with rollback pending");
`endif

endmodule

`default_nettype wire
